/* rtl/core/rational_arithmetic_unit_defines.svh */
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion wrappers on i_clk; RAU_ASSERT is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// check while out of reset
`define RAU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check at every edge, reset included
`define RAU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Command and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// Sequence: the products in S_MUL, the combine in S_SUM, the binary gcd loop in S_GCD,
// the exact division in S_DIV and the range check in S_FIN; S_SUM ends early on a zero
// denominator or a zero sum. The gcd loop's length varies with the operands.
// One item at a time; busy is high from the transfer until the result strobe.
// The result is strobed on o_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply or divide two fractions with a bit-serial multiplier,
// a binary gcd and bit-serial exact division, then reduce and range-check.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic signed [31:0]  i_a_num,
    input  logic signed [31:0]  i_a_den,
    input  logic signed [31:0]  i_b_num,
    input  logic signed [31:0]  i_b_den,
    output logic                o_valid,
    output logic signed [31:0]  o_res_num,
    output logic [30:0]         o_res_den,
    output logic [1:0]          o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] MUL_LAST = CW'(VALUE_WIDTH - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);
    localparam logic [PW-1:0] LIMIT    = (PW'(1) << (VALUE_WIDTH - 1)) - PW'(1);

    rau_pkg::t_state r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic          r_zden, n_zden;
    logic [W-1:0]  r_am, n_am, r_adm, n_adm, r_bm, n_bm, r_bdm, n_bdm;
    logic          r_as, n_as, r_ads, n_ads, r_bs, n_bs, r_bds, n_bds;
    logic [1:0]    r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt, r_k, n_k;
    logic [PW-1:0] r_mc, n_mc, r_acc, n_acc;
    logic [W-1:0]  r_mp, n_mp;
    logic [PW-1:0] r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic [PW-1:0] r_u, n_u, r_v, n_v, r_g, n_g;
    logic [PW-1:0] r_qn, n_qn, r_qd, n_qd, r_rn, n_rn, r_rd, n_rd;
    logic          r_neg, n_neg;
    logic          r_valid, n_valid;
    logic [31:0]   r_res_num, n_res_num;
    logic [30:0]   r_res_den, n_res_den;
    logic [1:0]    r_status, n_status;

    logic [W-1:0]  in_an, in_ad, in_bn, in_bd;
    logic [W-1:0]  sel_x, sel_y;
    logic [PW-1:0] mc_cur, acc_cur, acc_nxt;
    logic [W-1:0]  mp_cur;
    logic          s0, s1, sd;
    logic [PW-1:0] sum_n;
    logic          sum_neg;
    logic [PW:0]   rn_sh, rd_sh, rn_sub, rd_sub;
    logic [PW-1:0] qn_nxt, qd_nxt, rn_nxt, rd_nxt;
    logic [PW-1:0] fin_v;
    logic [W-1:0]  fin_low;

    assign in_an = i_a_num[W-1:0];
    assign in_ad = i_a_den[W-1:0];
    assign in_bn = i_b_num[W-1:0];
    assign in_bd = i_b_den[W-1:0];

    always_comb begin
        case (r_cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                case (r_idx)
                    2'd0:    begin sel_x = r_am;  sel_y = r_bdm; end
                    2'd1:    begin sel_x = r_bm;  sel_y = r_adm; end
                    default: begin sel_x = r_adm; sel_y = r_bdm; end
                endcase
            end
            rau_pkg::CMD_MUL: begin
                if (r_idx == 2'd2) begin
                    sel_x = r_adm; sel_y = r_bdm;
                end else begin
                    sel_x = r_am;  sel_y = r_bm;
                end
            end
            default: begin
                if (r_idx == 2'd2) begin
                    sel_x = r_adm; sel_y = r_bm;
                end else begin
                    sel_x = r_am;  sel_y = r_bdm;
                end
            end
        endcase
    end

    assign mc_cur  = (r_cnt == '0) ? PW'(sel_x) : r_mc;
    assign mp_cur  = (r_cnt == '0) ? sel_y : r_mp;
    assign acc_cur = (r_cnt == '0) ? '0 : r_acc;
    assign acc_nxt = acc_cur + (mp_cur[0] ? mc_cur : '0);

    always_comb begin
        case (r_cmd)
            rau_pkg::CMD_ADD: begin
                s0 = (r_p0 != '0) && (r_as ^ r_bds);
                s1 = (r_p1 != '0) && (r_bs ^ r_ads);
                sd = r_ads ^ r_bds;
            end
            rau_pkg::CMD_SUB: begin
                s0 = (r_p0 != '0) && (r_as ^ r_bds);
                s1 = (r_p1 != '0) && !(r_bs ^ r_ads);
                sd = r_ads ^ r_bds;
            end
            rau_pkg::CMD_MUL: begin
                s0 = r_as ^ r_bs;
                s1 = 1'b0;
                sd = r_ads ^ r_bds;
            end
            default: begin
                s0 = r_as ^ r_bds;
                s1 = 1'b0;
                sd = r_ads ^ r_bs;
            end
        endcase
        if (r_cmd == rau_pkg::CMD_ADD || r_cmd == rau_pkg::CMD_SUB) begin
            if (s0 == s1) begin
                sum_n = r_p0 + r_p1;  sum_neg = s0;
            end else if (r_p0 >= r_p1) begin
                sum_n = r_p0 - r_p1;  sum_neg = s0;
            end else begin
                sum_n = r_p1 - r_p0;  sum_neg = s1;
            end
        end else begin
            sum_n = r_p0;
            sum_neg = s0;
        end
    end

    assign rn_sh  = {r_rn, r_qn[PW-1]};
    assign rd_sh  = {r_rd, r_qd[PW-1]};
    assign rn_sub = rn_sh - {1'b0, r_g};
    assign rd_sub = rd_sh - {1'b0, r_g};
    assign rn_nxt = rn_sub[PW] ? rn_sh[PW-1:0] : rn_sub[PW-1:0];
    assign rd_nxt = rd_sub[PW] ? rd_sh[PW-1:0] : rd_sub[PW-1:0];
    assign qn_nxt = {r_qn[PW-2:0], !rn_sub[PW]};
    assign qd_nxt = {r_qd[PW-2:0], !rd_sub[PW]};

    assign fin_v   = r_neg ? (PW'(0) - r_qn) : r_qn;
    assign fin_low = fin_v[W-1:0];

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;  n_zden = r_zden;
        n_am = r_am;  n_adm = r_adm;  n_bm = r_bm;  n_bdm = r_bdm;
        n_as = r_as;  n_ads = r_ads;  n_bs = r_bs;  n_bds = r_bds;
        n_idx = r_idx;  n_cnt = r_cnt;  n_k = r_k;
        n_mc = r_mc;  n_mp = r_mp;  n_acc = r_acc;
        n_p0 = r_p0;  n_p1 = r_p1;  n_p2 = r_p2;
        n_u = r_u;  n_v = r_v;  n_g = r_g;
        n_qn = r_qn;  n_qd = r_qd;  n_rn = r_rn;  n_rd = r_rd;
        n_neg = r_neg;
        n_valid = 1'b0;
        n_res_num = r_res_num;  n_res_den = r_res_den;  n_status = r_status;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd  = i_command;
                    n_zden = (in_ad == '0) || (in_bd == '0);
                    n_as  = in_an[W-1];  n_am  = in_an[W-1] ? W'(0) - in_an : in_an;
                    n_ads = in_ad[W-1];  n_adm = in_ad[W-1] ? W'(0) - in_ad : in_ad;
                    n_bs  = in_bn[W-1];  n_bm  = in_bn[W-1] ? W'(0) - in_bn : in_bn;
                    n_bds = in_bd[W-1];  n_bdm = in_bd[W-1] ? W'(0) - in_bd : in_bd;
                    n_idx = 2'd0;
                    n_cnt = '0;
                    n_state = rau_pkg::S_MUL;
                end
            end
            rau_pkg::S_MUL: begin
                n_mc  = {mc_cur[PW-2:0], 1'b0};
                n_mp  = {1'b0, mp_cur[W-1:1]};
                n_acc = acc_nxt;
                if (r_cnt == MUL_LAST) begin
                    n_cnt = '0;
                    case (r_idx)
                        2'd0:    n_p0 = acc_nxt;
                        2'd1:    n_p1 = acc_nxt;
                        default: n_p2 = acc_nxt;
                    endcase
                    if (r_idx == 2'd2) begin
                        n_state = rau_pkg::S_SUM;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            rau_pkg::S_SUM: begin
                if (r_zden || r_p2 == '0) begin
                    n_valid = 1'b1;  n_res_num = '0;  n_res_den = 31'd1;
                    n_status = rau_pkg::ST_ZERO_DEN;
                    n_state = rau_pkg::S_IDLE;
                end else if (sum_n == '0) begin
                    n_valid = 1'b1;  n_res_num = '0;  n_res_den = 31'd1;
                    n_status = rau_pkg::ST_OK;
                    n_state = rau_pkg::S_IDLE;
                end else begin
                    n_u = sum_n;  n_v = r_p2;  n_k = '0;
                    n_qn = sum_n;  n_qd = r_p2;
                    n_neg = sum_neg ^ sd;
                    n_state = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD: begin
                if (r_u == '0) begin
                    n_g = r_v << r_k;
                    n_rn = '0;  n_rd = '0;  n_cnt = '0;
                    n_state = rau_pkg::S_DIV;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;  n_v = r_v >> 1;  n_k = r_k + CW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = r_u - r_v;
                end else begin
                    n_v = r_v - r_u;
                end
            end
            rau_pkg::S_DIV: begin
                n_qn = qn_nxt;  n_qd = qd_nxt;  n_rn = rn_nxt;  n_rd = rd_nxt;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = rau_pkg::S_FIN;
                end
            end
            rau_pkg::S_FIN: begin
                n_valid = 1'b1;
                n_state = rau_pkg::S_IDLE;
                if (r_qd > LIMIT || (r_neg ? (r_qn > LIMIT + PW'(1)) : (r_qn > LIMIT))) begin
                    n_res_num = '0;  n_res_den = 31'd1;
                    n_status = rau_pkg::ST_OVERFLOW;
                end else begin
                    n_res_num = 32'(signed'(fin_low));
                    n_res_den = 31'(r_qd[W-2:0]);
                    n_status = rau_pkg::ST_OK;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_zden <= n_zden;
        r_am <= n_am;  r_adm <= n_adm;  r_bm <= n_bm;  r_bdm <= n_bdm;
        r_as <= n_as;  r_ads <= n_ads;  r_bs <= n_bs;  r_bds <= n_bds;
        r_idx <= n_idx;  r_cnt <= n_cnt;  r_k <= n_k;
        r_mc <= n_mc;  r_mp <= n_mp;  r_acc <= n_acc;
        r_p0 <= n_p0;  r_p1 <= n_p1;  r_p2 <= n_p2;
        r_u <= n_u;  r_v <= n_v;  r_g <= n_g;
        r_qn <= n_qn;  r_qd <= n_qd;  r_rn <= n_rn;  r_rd <= n_rd;
        r_neg <= n_neg;
        r_res_num <= n_res_num;  r_res_den <= n_res_den;  r_status <= n_status;
    end

    assign busy      = (r_state != rau_pkg::S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

endmodule

/* rtl/core/rau_checker.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [31:0] o_res_num,
    input logic [30:0]        o_res_den,
    input logic [1:0]         o_status
);

    `RAU_ASSERT(a_strobe_single, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `RAU_ASSERT(a_busy_after_transfer, (start && !busy) |=> busy, "busy low after a transfer")
    `RAU_ASSERT(a_error_result,
        (o_valid && o_status != rau_pkg::ST_OK) |-> (o_res_num == 32'sd0 && o_res_den == 31'd1),
        "error result not 0/1")
    `RAU_ASSERT(a_den_nonzero,
        o_valid |-> (o_res_den != 31'd0 && o_status <= rau_pkg::ST_OVERFLOW),
        "bad denominator or status")
    `RAU_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_valid && !busy), "not idle after reset")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_res_num (o_res_num),
    .o_res_den (o_res_den),
    .o_status  (o_status)
);

/* verif/rational_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations through the start/busy handshake, predicts each
// reduced result with a sign-magnitude model and a Euclidean gcd, and checks
// every strobed result in order against the predictions.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VW        = 32;
    localparam int          N_RANDOM  = 1230;
    localparam longint      MAX_CYCLES = 2_000_000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
    } t_op;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
    } t_frac;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic signed [31:0] i_a_num;
    logic signed [31:0] i_a_den;
    logic signed [31:0] i_b_num;
    logic signed [31:0] i_b_den;
    logic               o_valid;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic [1:0]         o_status;

    t_op    pending_ops[$];
    t_frac  expected_fracs[$];
    int     errors;
    int     sent;
    int     received;
    int     err_results;
    int     ovf_results;
    longint cycles;
    bit     hold_sender;
    bit     quiet_sender;
    int     cmd_count[4];

    rational_arithmetic_unit #(.VALUE_WIDTH(VW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magnitude(logic signed [31:0] v);
        return v[31] ? 64'(-64'(v)) : 64'(v);
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // signed sum of two sign-magnitude terms
    function automatic void sm_sum(input bit xs, input logic [63:0] xm, input bit ys,
                                   input logic [63:0] ym, output bit rs,
                                   output logic [63:0] rm);
        if (xs == ys) begin
            rm = xm + ym;
            rs = xs;
        end else if (xm >= ym) begin
            rm = xm - ym;
            rs = xs;
        end else begin
            rm = ym - xm;
            rs = ys;
        end
        if (rm == 0) rs = 1'b0;
    endfunction

    function automatic t_frac reduce_fraction(t_op op);
        t_frac       r;
        logic [63:0] anm, adm, bnm, bdm, p, q, nm, dm, g;
        bit          ans, ads, bns, bds, ps, qs, ns, ds;
        anm = magnitude(op.an); ans = op.an[31];
        adm = magnitude(op.ad); ads = op.ad[31];
        bnm = magnitude(op.bn); bns = op.bn[31];
        bdm = magnitude(op.bd); bds = op.bd[31];
        r = '{num: 0, den: 31'd1, status: rau_pkg::ST_ZERO_DEN};
        if (adm == 0 || bdm == 0) return r;
        dm = adm * bdm;
        ds = ads ^ bds;
        case (op.cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                p = anm * bdm; ps = (p != 0) && (ans ^ bds);
                q = bnm * adm; qs = (q != 0) && (bns ^ ads);
                if (op.cmd == rau_pkg::CMD_SUB && q != 0) qs = ~qs;
                sm_sum(ps, p, qs, q, ns, nm);
            end
            rau_pkg::CMD_MUL: begin
                nm = anm * bnm;
                ns = ans ^ bns;
            end
            default: begin
                nm = anm * bdm;
                ns = ans ^ bds;
                dm = adm * bnm;
                ds = ads ^ bns;
            end
        endcase
        if (dm == 0) return r;
        r.status = rau_pkg::ST_OK;
        if (nm == 0) return r;
        g = euclid_gcd(nm, dm);
        nm = nm / g;
        dm = dm / g;
        ns = ns ^ ds;
        if (dm > 64'h7FFF_FFFF || nm > (ns ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.num = ns ? 32'(-nm) : 32'(nm);
        r.den = 31'(dm);
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 0;
            3:       return $urandom;
            4, 5:    return $signed(32'($urandom_range(0, 40))) - 20;
            6:       return $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return $signed(32'($urandom)) >>> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic queue_op(logic [1:0] c, logic signed [31:0] an, logic signed [31:0] ad,
                            logic signed [31:0] bn, logic signed [31:0] bd);
        pending_ops.push_back('{cmd: c, an: an, ad: ad, bn: bn, bd: bd});
    endtask

    // driver
    always @(posedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_fracs.push_back(reduce_fraction(
                '{cmd: i_command, an: i_a_num, ad: i_a_den, bn: i_b_num, bd: i_b_den}));
            cmd_count[i_command]++;
            sent++;
            start <= 1'b0;
        end else if (!start && pending_ops.size() > 0 && !hold_sender
                     && (quiet_sender || $urandom_range(0, 99) >= 8)) begin
            op = pending_ops.pop_front();
            i_command <= op.cmd;
            i_a_num   <= op.an;
            i_a_den   <= op.ad;
            i_b_num   <= op.bn;
            i_b_den   <= op.bd;
            start     <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frac exp_r;
        cycles++;
        if (i_rst_n && o_valid) begin
            received++;
            if (expected_fracs.size() == 0) begin
                $error("unexpected result num=%0d den=%0d status=%0d",
                       o_res_num, o_res_den, o_status);
                errors++;
            end else begin
                exp_r = expected_fracs.pop_front();
                if (exp_r.status == rau_pkg::ST_ZERO_DEN) err_results++;
                if (exp_r.status == rau_pkg::ST_OVERFLOW) ovf_results++;
                if (o_res_num !== exp_r.num) begin
                    $error("res_num expected %0d actual %0d", exp_r.num, o_res_num);
                    errors++;
                end
                if (o_res_den !== exp_r.den) begin
                    $error("res_den expected %0d actual %0d", exp_r.den, o_res_den);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [1:0] c;
        errors = 0; sent = 0; received = 0; cycles = 0;
        err_results = 0; ovf_results = 0;
        hold_sender = 1'b0; quiet_sender = 1'b0;
        start = 1'b0; i_command = rau_pkg::CMD_ADD;
        i_a_num = 0; i_a_den = 1; i_b_num = 0; i_b_den = 1;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_op(rau_pkg::CMD_ADD, 1, 2, 1, 3);
        queue_op(rau_pkg::CMD_SUB, 1, 2, 1, 2);
        queue_op(rau_pkg::CMD_MUL, -3, 4, 2, -9);
        queue_op(rau_pkg::CMD_DIV, 5, 7, -10, 21);
        queue_op(rau_pkg::CMD_ADD, 1, 0, 1, 1);
        queue_op(rau_pkg::CMD_MUL, 1, 1, 1, 0);
        queue_op(rau_pkg::CMD_DIV, 1, 1, 1, 0);
        queue_op(rau_pkg::CMD_DIV, 3, 4, 0, 5);
        queue_op(rau_pkg::CMD_MUL, 0, -5, 7, 3);
        queue_op(rau_pkg::CMD_ADD, 32'sh8000_0000, 1, 0, 1);
        queue_op(rau_pkg::CMD_MUL, 32'sh8000_0000, 1, -1, 1);
        queue_op(rau_pkg::CMD_ADD, 32'sh7FFF_FFFF, 1, 1, 1);
        queue_op(rau_pkg::CMD_SUB, 32'sh8000_0000, 1, 1, 1);
        queue_op(rau_pkg::CMD_MUL, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000);
        queue_op(rau_pkg::CMD_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_op(rau_pkg::CMD_DIV, 1, 32'sh7FFF_FFFF, 3, 1);
        queue_op(rau_pkg::CMD_ADD, 1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFE);
        queue_op(rau_pkg::CMD_SUB, -1, -1, -1, -1);
        queue_op(rau_pkg::CMD_DIV, -6, -4, 3, -2);
        queue_op(rau_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h7FFF_FFFF);

        wait (pending_ops.size() == 0 && expected_fracs.size() == 0 && !busy && !start);
        hold_sender = 1'b1;
        repeat (5) @(posedge i_clk);
        hold_sender = 1'b0;

        for (int i = 0; i < N_RANDOM; i++) begin
            c = 2'($urandom_range(0, 3));
            queue_op(c, pick_value(), ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_value(),
                     pick_value(), ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_value());
            if (i == 400) begin
                quiet_sender = 1'b1;
                wait (pending_ops.size() == 0);
                hold_sender = 1'b1;
                wait (expected_fracs.size() == 0 && !busy && !start);
                hold_sender = 1'b0;
            end
            if (i == 700) begin
                wait (pending_ops.size() == 0);
                quiet_sender = 1'b0;
            end
        end

        wait (pending_ops.size() == 0 && !start && expected_fracs.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d operations (add %0d, sub %0d, mul %0d, div %0d), checked %0d results",
                 sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], received);
        $display("Results flagged zero denominator: %0d, overflow: %0d",
                 err_results, ovf_results);
        if (errors == 0 && expected_fracs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycles >= MAX_CYCLES);
        $display("Timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_checker.sv
verif/rational_arithmetic_unit_tb.sv
